// ===== rtl/point_set_proximity_filter_core_defines.svh =====
// assertion macros for the point set proximity filter checker
// no dependencies; included by the checker file only
`ifndef POINT_SET_PROXIMITY_FILTER_CORE_DEFINES_SVH
`define POINT_SET_PROXIMITY_FILTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PSP_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("psp check failed");

// next-cycle implication, disabled while reset is low
`define PSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("psp check failed");

`endif

// ===== rtl/psp_pkg.sv =====
// shared types, codes and constants of the point set proximity filter
// no dependencies
`timescale 1ns / 1ps

package psp_pkg;

  localparam int CAP_DEF = 32;
  localparam int DIM_DEF = 16;

  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 5;
  localparam int SURV_W   = 6;
  localparam int NVAR_W   = 5;
  localparam int SFAC_W   = 16;
  localparam int SMAX_W   = 6;
  localparam int EFAC_W   = 24;
  localparam int CFG_W    = 24;
  localparam int CFGIDX_W = 2;

  localparam int ENV_W  = EFAC_W + WORD_W;  // 56
  localparam int HALF_W = ENV_W / 2;        // 28
  localparam int LIM_W  = 2 * ENV_W;        // 112
  localparam int MAG_W  = WORD_W + 1;       // 33
  localparam int SQ_W   = 2 * WORD_W + 1;   // 65, square of a 33-bit magnitude
  localparam int FRAC_ALIGN = 16;           // Q.32 sum to Q.48 limit

  localparam logic [NVAR_W-1:0] NVAR_RST = NVAR_W'(16);
  localparam logic [SFAC_W-1:0] SFAC_RST = SFAC_W'(512);
  localparam logic [SMAX_W-1:0] SMAX_RST = SMAX_W'(32);
  localparam logic [EFAC_W-1:0] EFAC_RST = EFAC_W'(25600);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_POINT = 2'd0,
    FUNC_ITER  = 2'd1,
    FUNC_RUN   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [CFGIDX_W-1:0] {
    CFG_NVAR = 2'd0,
    CFG_SFAC = 2'd1,
    CFG_SMAX = 2'd2,
    CFG_EFAC = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZFILL,
    ST_CAPS,
    ST_TRIM,
    ST_LIM1,
    ST_LIM2,
    ST_LIM3,
    ST_ISSUE,
    ST_WAIT,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // control from the sequencer to the distance datapath
  typedef struct packed {
    logic vld;    // memory read data valid this cycle
    logic use_w;  // word lies within the coordinates in use
    logic clr;    // clear the accumulator
  } dist_ctrl_t;

endpackage

// ===== rtl/psp_if.sv =====
// input and result channel interfaces of the point set proximity filter
// depends on psp_pkg
`timescale 1ns / 1ps

interface psp_in_if import psp_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;
  logic                     last;
  logic [WORD_W-1:0]        radius;

  modport source (output valid, func, value, last, radius, input ready);
  modport sink   (input valid, func, value, last, radius, output ready);
endinterface

interface psp_out_if import psp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  point_index;
  logic [SURV_W-1:0] survivors;
  logic              none_left;
  logic              end_of_run;

  modport source (output valid, point_index, survivors, none_left, end_of_run, input ready);
  modport sink   (input valid, point_index, survivors, none_left, end_of_run, output ready);
endinterface

// ===== rtl/psp_ram.sv =====
// simple dual-port synchronous memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module psp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/psp_dist.sv =====
// squared distance datapath: magnitude, square and accumulate stages
// depends on psp_pkg
`timescale 1ns / 1ps

module psp_dist import psp_pkg::*; #(
  parameter int ACC_W = 69
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dist_ctrl_t        ctrl_i,
  input  logic [WORD_W-1:0] pt_word_i,
  input  logic [WORD_W-1:0] it_word_i,
  output logic [ACC_W-1:0]  acc_o,
  output logic              busy_o
);

  logic             va_q, vb_q;
  logic [MAG_W-1:0] mag_q;
  logic [SQ_W-1:0]  sq_q;
  logic [ACC_W-1:0] acc_q;
  logic [MAG_W-1:0] diff;
  logic [MAG_W-1:0] mag_d;
  logic [2*MAG_W-1:0] prod;

  // 33-bit difference of sign-extended words, then magnitude
  assign diff  = {it_word_i[WORD_W-1], it_word_i} - {pt_word_i[WORD_W-1], pt_word_i};
  assign mag_d = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
  assign prod  = mag_q * mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= ctrl_i.vld & ctrl_i.use_w;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    sq_q  <= prod[SQ_W-1:0];
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (vb_q) begin
      acc_q <= acc_q + ACC_W'(sq_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = ctrl_i.vld | va_q | vb_q;

endmodule

// ===== rtl/point_set_proximity_filter_core.sv =====
// top level of the point set proximity filter: sequencer, ring store, run logic
// depends on psp_pkg, psp_if, psp_ram, psp_dist
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_i     | in  | valid / ready | func, value, last, radius
//  out_o    | out | valid / ready | point_index, survivors, none_left, end_of_run
//  cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_wdata_i
//
// a coordinate transaction is taken in idle; completing a point or iterate early
//   then zeroes the remaining words up to DIM-1 in the zero-fill state
// a run passes the setup states CAPS, TRIM, LIM1, LIM2 and LIM3, then for each stored
//   point the single read port of the point memory walks DIM words, the distance
//   pipeline drains and the point is kept or dropped, then the results are emitted
// reset clears the point count and the ring pointer; the memories hold no reset value
// input ready is high only in idle; a stalled result holds in the output register
//   while the next transaction may already be taken
`timescale 1ns / 1ps

module point_set_proximity_filter_core import psp_pkg::*; #(
  parameter int CAP = CAP_DEF,
  parameter int DIM = DIM_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFGIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  psp_in_if.sink              in_i,
  psp_out_if.source           out_o
);

  localparam int SLOT_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int CUR_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int NV_W   = $clog2(DIM + 1);
  localparam int PDEPTH = CAP * DIM;
  localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int ACC_W  = SQ_W + ((DIM > 1) ? $clog2(DIM) : 1);
  localparam int CAPL_W = SFAC_W + NV_W - 8;

  // configuration registers
  logic [NVAR_W-1:0] nvar_q;
  logic [SFAC_W-1:0] sfac_q;
  logic [SMAX_W-1:0] smax_q;
  logic [EFAC_W-1:0] efac_q;

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic             kind_q, kind_d;
  logic [CUR_W-1:0] zp_q, zp_d;
  logic [SLOT_W-1:0] zslot_q, zslot_d;
  logic             zkind_q, zkind_d;

  // run state
  logic [WORD_W-1:0] rad_q, rad_d;
  logic [ENV_W-1:0]  env_q, env_d;
  logic [ENV_W-1:0]  prod_q, prod_d;
  logic [LIM_W-1:0]  lim_q, lim_d;
  logic [CAPL_W-1:0] capl_q, capl_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic [SLOT_W-1:0] src_q, src_d;
  logic [SLOT_W-1:0] dst_q, dst_d;
  logic [CUR_W-1:0]  j_q, j_d;
  logic              rdv_q, rdv_d;
  logic [CUR_W-1:0]  jrd_q, jrd_d;
  logic              userd_q, userd_d;
  logic [CNT_W-1:0]  e_q, e_d;

  // result register
  logic              ov_q, ov_d;
  logic [IDX_W-1:0]  opi_q, opi_d;
  logic [SURV_W-1:0] osv_q, osv_d;
  logic              onl_q, onl_d;
  logic              oend_q, oend_d;

  // memory ports
  logic              p_we, i_we;
  logic [PA_W-1:0]   p_waddr, p_raddr;
  logic [CUR_W-1:0]  i_waddr, i_raddr;
  logic [WORD_W-1:0] p_wdata, i_wdata, p_rdata, i_rdata;

  dist_ctrl_t        dctl;
  logic [ACC_W-1:0]  acc;
  logic              dbusy;

  // helpers
  logic [NV_W-1:0]   n_eff;
  logic [CUR_W-1:0]  cur_eff;
  logic              full;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_nf, slot_p1, app_slot;
  logic              app_done;
  logic [SLOT_W:0]   trim_sum;
  logic [CNT_W-1:0]  keep_cnt;
  logic [SLOT_W:0]   src_sum, dst_sum;
  logic              keep_pt;
  logic [LIM_W-1:0]  dist_al;
  logic              in_acc;

  psp_ram #(.DEPTH(PDEPTH), .WIDTH(WORD_W)) u_pmem (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  psp_ram #(.DEPTH(DIM), .WIDTH(WORD_W)) u_imem (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (i_wdata),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  psp_dist #(.ACC_W(ACC_W)) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (dctl),
    .pt_word_i (p_rdata),
    .it_word_i (i_rdata),
    .acc_o     (acc),
    .busy_o    (dbusy)
  );

  // coordinates in use, clamped to 1..DIM
  always_comb begin
    if (nvar_q == '0) begin
      n_eff = NV_W'(1);
    end else if (32'(nvar_q) > DIM) begin
      n_eff = NV_W'(DIM);
    end else begin
      n_eff = NV_W'(nvar_q);
    end
  end

  assign in_acc = in_i.valid && (state_q == ST_IDLE);
  assign in_i.ready = (state_q == ST_IDLE);

  // coordinate placement for an append: ring slot after an optional drop
  assign cur_eff  = (cursor_q != '0 && kind_q != in_i.func[0]) ? '0 : cursor_q;
  assign full     = (cur_eff == '0) && (32'(count_q) >= CAP);
  assign slot_sum = {1'b0, oldest_q} + (SLOT_W+1)'(count_q);
  assign slot_nf  = (32'(slot_sum) >= CAP) ? SLOT_W'(32'(slot_sum) - CAP)
                                           : slot_sum[SLOT_W-1:0];
  assign slot_p1  = (32'(oldest_q) + 1 >= CAP) ? '0 : oldest_q + SLOT_W'(1);
  assign app_slot = full ? oldest_q : slot_nf;
  assign app_done = in_i.last || (32'(cur_eff) + 1 >= 32'(n_eff));

  // trim: largest count allowed by both bounds
  always_comb begin
    keep_cnt = count_q;
    if (32'(keep_cnt) > 32'(smax_q)) keep_cnt = CNT_W'(smax_q);
    if (32'(keep_cnt) > 32'(capl_q)) keep_cnt = CNT_W'(capl_q);
  end
  assign trim_sum = {1'b0, oldest_q} + (SLOT_W+1)'(count_q - keep_cnt);

  assign src_sum = {1'b0, src_q} + (SLOT_W+1)'(1);
  assign dst_sum = {1'b0, dst_q} + (SLOT_W+1)'(1);

  // squared distance in Q.48 against the squared envelope
  assign dist_al = LIM_W'({acc, {FRAC_ALIGN{1'b0}}});
  assign keep_pt = !(dist_al > lim_q);

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvar_q <= NVAR_RST;
      sfac_q <= SFAC_RST;
      smax_q <= SMAX_RST;
      efac_q <= EFAC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_NVAR: nvar_q <= cfg_wdata_i[NVAR_W-1:0];
        CFG_SFAC: sfac_q <= cfg_wdata_i[SFAC_W-1:0];
        CFG_SMAX: smax_q <= cfg_wdata_i[SMAX_W-1:0];
        CFG_EFAC: efac_q <= cfg_wdata_i[EFAC_W-1:0];
        default:  ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      oldest_q <= '0;
      cursor_q <= '0;
      kind_q   <= 1'b0;
      rdv_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      cursor_q <= cursor_d;
      kind_q   <= kind_d;
      rdv_q    <= rdv_d;
      ov_q     <= ov_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    zp_q    <= zp_d;
    zslot_q <= zslot_d;
    zkind_q <= zkind_d;
    rad_q   <= rad_d;
    env_q   <= env_d;
    prod_q  <= prod_d;
    lim_q   <= lim_d;
    capl_q  <= capl_d;
    k_q     <= k_d;
    kept_q  <= kept_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    j_q     <= j_d;
    jrd_q   <= jrd_d;
    userd_q <= userd_d;
    e_q     <= e_d;
    opi_q   <= opi_d;
    osv_q   <= osv_d;
    onl_q   <= onl_d;
    oend_q  <= oend_d;
  end

  // sequencer: next state, memory ports and datapath control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    oldest_d = oldest_q;
    cursor_d = cursor_q;
    kind_d   = kind_q;
    zp_d     = zp_q;
    zslot_d  = zslot_q;
    zkind_d  = zkind_q;
    rad_d    = rad_q;
    env_d    = env_q;
    prod_d   = prod_q;
    lim_d    = lim_q;
    capl_d   = capl_q;
    k_d      = k_q;
    kept_d   = kept_q;
    src_d    = src_q;
    dst_d    = dst_q;
    j_d      = j_q;
    rdv_d    = 1'b0;
    jrd_d    = jrd_q;
    userd_d  = 1'b0;
    e_d      = e_q;
    ov_d     = ov_q && !out_o.ready;
    opi_d    = opi_q;
    osv_d    = osv_q;
    onl_d    = onl_q;
    oend_d   = oend_q;

    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    p_raddr = PA_W'(32'(src_q) * DIM + 32'(j_q));
    i_we    = 1'b0;
    i_waddr = '0;
    i_wdata = '0;
    i_raddr = j_q;

    dctl.vld   = rdv_q;
    dctl.use_w = userd_q;
    dctl.clr   = 1'b0;

    // copy of the word read last cycle into the compacted slot
    if (rdv_q) begin
      p_we    = 1'b1;
      p_waddr = PA_W'(32'(dst_q) * DIM + 32'(jrd_q));
      p_wdata = p_rdata;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.func == FUNC_POINT || in_i.func == FUNC_ITER) begin
            kind_d = in_i.func[0];
            if (in_i.func == FUNC_POINT) begin
              p_we    = 1'b1;
              p_waddr = PA_W'(32'(app_slot) * DIM + 32'(cur_eff));
              p_wdata = in_i.value;
              if (full) begin
                oldest_d = slot_p1;
                count_d  = count_q - CNT_W'(1);
              end
            end else begin
              i_we    = 1'b1;
              i_waddr = cur_eff;
              i_wdata = in_i.value;
            end
            if (app_done) begin
              cursor_d = '0;
              if (in_i.func == FUNC_POINT) begin
                count_d = (full ? count_q : count_q + CNT_W'(1));
              end
              if (32'(cur_eff) + 1 < DIM) begin
                zp_d    = CUR_W'(32'(cur_eff) + 1);
                zslot_d = app_slot;
                zkind_d = in_i.func[0];
                state_d = ST_ZFILL;
              end
            end else begin
              cursor_d = cur_eff + CUR_W'(1);
            end
          end else if (in_i.func == FUNC_RUN) begin
            cursor_d = '0;
            rad_d    = in_i.radius;
            state_d  = ST_CAPS;
          end
        end
      end

      // zero the tail of a point or iterate completed early
      ST_ZFILL: begin
        if (zkind_q) begin
          i_we    = 1'b1;
          i_waddr = zp_q;
        end else begin
          p_we    = 1'b1;
          p_waddr = PA_W'(32'(zslot_q) * DIM + 32'(zp_q));
        end
        if (32'(zp_q) == DIM - 1) begin
          state_d = ST_IDLE;
        end else begin
          zp_d = zp_q + CUR_W'(1);
        end
      end

      ST_CAPS: begin
        capl_d  = CAPL_W'((32'(sfac_q) * 32'(n_eff)) >> 8);
        env_d   = ENV_W'(efac_q) * ENV_W'(rad_q);
        state_d = ST_TRIM;
      end

      ST_TRIM: begin
        count_d  = keep_cnt;
        oldest_d = (32'(trim_sum) >= CAP) ? SLOT_W'(32'(trim_sum) - CAP)
                                          : trim_sum[SLOT_W-1:0];
        prod_d   = ENV_W'(env_q[ENV_W-1:HALF_W]) * ENV_W'(env_q[ENV_W-1:HALF_W]);
        state_d  = ST_LIM1;
      end

      // envelope squared from three half-width partial products
      ST_LIM1: begin
        lim_d   = {prod_q, {ENV_W{1'b0}}};
        prod_d  = ENV_W'(env_q[ENV_W-1:HALF_W]) * ENV_W'(env_q[HALF_W-1:0]);
        state_d = ST_LIM2;
      end

      ST_LIM2: begin
        lim_d   = lim_q + (LIM_W'(prod_q) << (HALF_W + 1));
        prod_d  = ENV_W'(env_q[HALF_W-1:0]) * ENV_W'(env_q[HALF_W-1:0]);
        state_d = ST_LIM3;
      end

      ST_LIM3: begin
        lim_d     = lim_q + LIM_W'(prod_q);
        dctl.clr  = 1'b1;
        k_d       = '0;
        kept_d    = '0;
        src_d     = oldest_q;
        dst_d     = oldest_q;
        j_d       = '0;
        e_d       = '0;
        state_d   = (count_q == '0) ? ST_EMIT : ST_ISSUE;
      end

      // walk all DIM words of the point; the tail is copied but not summed
      ST_ISSUE: begin
        rdv_d   = 1'b1;
        jrd_d   = j_q;
        userd_d = (32'(j_q) < 32'(n_eff));
        if (32'(j_q) == DIM - 1) begin
          j_d     = '0;
          state_d = ST_WAIT;
        end else begin
          j_d = j_q + CUR_W'(1);
        end
      end

      ST_WAIT: begin
        if (!dbusy) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        dctl.clr = 1'b1;
        if (keep_pt) begin
          kept_d = kept_q + CNT_W'(1);
          dst_d  = (32'(dst_sum) >= CAP) ? '0 : dst_sum[SLOT_W-1:0];
        end
        src_d = (32'(src_sum) >= CAP) ? '0 : src_sum[SLOT_W-1:0];
        k_d   = k_q + CNT_W'(1);
        if (k_q + CNT_W'(1) == count_q) begin
          count_d = keep_pt ? kept_q + CNT_W'(1) : kept_q;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_ISSUE;
        end
      end

      ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d   = 1'b1;
          opi_d  = IDX_W'(e_q);
          osv_d  = SURV_W'(count_q);
          onl_d  = (count_q == '0);
          oend_d = (count_q == '0) || (e_q + CNT_W'(1) == count_q);
          e_d    = e_q + CNT_W'(1);
          if ((count_q == '0) || (e_q + CNT_W'(1) == count_q)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_o.valid       = ov_q;
  assign out_o.point_index = opi_q;
  assign out_o.survivors   = osv_q;
  assign out_o.none_left   = onl_q;
  assign out_o.end_of_run  = oend_q;

endmodule

// ===== rtl/psp_chk.sv =====
// port-level checker of the point set proximity filter, bound to the top level
// depends on psp_pkg and point_set_proximity_filter_core_defines.svh
`timescale 1ns / 1ps
`include "point_set_proximity_filter_core_defines.svh"

module psp_chk import psp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [IDX_W-1:0]  out_point_index_i,
  input logic [SURV_W-1:0] out_survivors_i,
  input logic              out_none_left_i,
  input logic              out_end_of_run_i
);

  // empty marker is the single, final transaction of its run
  `PSP_ASSERT_NOW(a_empty_marker, clk_i, rst_ni, out_valid_i && out_none_left_i, out_point_index_i == '0 && out_survivors_i == '0 && out_end_of_run_i)

  // a transaction that is not the last leaves more survivors to list
  `PSP_ASSERT_NOW(a_index_in_run, clk_i, rst_ni, out_valid_i && !out_end_of_run_i, ({1'b0, out_point_index_i} + SURV_W'(1)) < out_survivors_i)

  // within a run the indices count up by one
  `PSP_ASSERT_NEXT(a_index_step, clk_i, rst_ni, out_valid_i && out_ready_i && !out_end_of_run_i, !out_valid_i || out_point_index_i == $past(out_point_index_i) + IDX_W'(1))

  // a stalled result holds
  `PSP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_point_index_i) && $stable(out_end_of_run_i))

endmodule

bind point_set_proximity_filter_core psp_chk u_psp_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_point_index_i (out_o.point_index),
  .out_survivors_i   (out_o.survivors),
  .out_none_left_i   (out_o.none_left),
  .out_end_of_run_i  (out_o.end_of_run)
);
